// ----- design/nrmc_pkg.sv -----
// Package for the RMC date/time extractor: character codes, widths and header lookup.
package nrmc_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned FIELD_W  = 48;
    localparam int unsigned SLOTS    = 6;
    localparam int unsigned OFFSET_W = 7;
    localparam int unsigned COMMA_W  = 4;
    localparam int unsigned HDR_W    = 3;
    localparam int unsigned IDX_W    = 3;

    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;  // '$'
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;  // ','
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;  // '\n'
    localparam logic [CHAR_W-1:0] CH_ACTIVE  = 8'h41;  // 'A'

    localparam logic [HDR_W-1:0]    HDR_LEN       = 3'd6;
    localparam logic [OFFSET_W-1:0] OFS_AFTER_HDR = 7'd6;
    localparam logic [OFFSET_W-1:0] OFS_TIME      = 7'd7;
    localparam logic [OFFSET_W-1:0] OFS_STATUS    = 7'd17;
    localparam logic [OFFSET_W-1:0] OFS_MAX       = 7'd127;
    localparam logic [COMMA_W-1:0]  DATE_COMMAS   = 4'd9;
    localparam logic [COMMA_W-1:0]  COMMA_MAX     = 4'd15;
    localparam logic [IDX_W-1:0]    DATE_LEN      = 3'd6;

    // "$GNRMC", one character per header position
    function automatic logic [CHAR_W-1:0] hdr_char(input logic [HDR_W-1:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = 8'h47;  // 'G'
            3'd2:    c = 8'h4E;  // 'N'
            3'd3:    c = 8'h52;  // 'R'
            3'd4:    c = 8'h4D;  // 'M'
            3'd5:    c = 8'h43;  // 'C'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- design/nmea_rmc_date_time_extractor.sv -----
// Top level: scans an NMEA byte stream for $GNRMC sentences and emits date, time and fix flag.
//
// Usage:
//   Slave channel (s_*): one received NMEA character per word in s_tdata.
//   Master channel (m_*): one word per complete $GNRMC sentence, sent when the
//   terminating newline is accepted. m_tdata[47:0] is the date as ASCII YYMMDD,
//   m_tdata[95:48] the time as ASCII hhmmss, first character in the top byte of
//   each field. m_tuser is the fix flag: 1 only for status 'A'; when 0 both
//   character fields are zero.
// Timing:
//   A byte can be accepted in every cycle while s_tready is high.
//   The newline's result is registered into the output or skid register.
//   The parser state is one set of registers updated per accepted byte.
// Stalls:
//   A two-entry output buffer (output register plus skid register) lets the
//   block keep taking bytes while a result waits. s_tready drops only while
//   both entries hold results; it returns the cycle after the receiver takes one.
// Reset:
//   aresetn low (synchronous) clears the parser to idle and empties the
//   output buffer. A '$' always restarts header matching and drops any
//   unfinished sentence without a result.
module nmea_rmc_date_time_extractor
    import nrmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [47:0] date_chars, [95:48] time_chars
    output logic        m_tuser    // [0] fix_active
);

    // parser state
    logic [HDR_W-1:0]    hdr_pos_reg,     hdr_pos_next;
    logic                in_sent_reg,     in_sent_next;
    logic [OFFSET_W-1:0] offset_reg,      offset_next;
    logic [COMMA_W-1:0]  commas_reg,      commas_next;
    logic                status_reg,      status_next;
    logic [IDX_W-1:0]    date_idx_reg,    date_idx_next;
    logic [FIELD_W-1:0]  date_store_reg,  date_store_next;
    logic [FIELD_W-1:0]  time_store_reg,  time_store_next;

    // output buffer
    logic                   out_valid_reg,  skid_valid_reg;
    logic [2*FIELD_W-1:0]   out_data_reg,   skid_data_reg;
    logic                   out_user_reg,   skid_user_reg;

    logic                   s_accept;
    logic                   out_pop;
    logic                   res_valid;
    logic [2*FIELD_W-1:0]   res_data;
    logic                   res_user;
    logic [FIELD_W-1:0]     date_yymmdd;
    logic [CHAR_W-1:0]      b;
    logic [OFFSET_W-1:0]    time_slot;

    assign b        = s_tdata;
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_pop  = out_valid_reg && m_tready;

    // DDMMYY -> YYMMDD
    assign date_yymmdd = {date_store_reg[15:0], date_store_reg[31:16], date_store_reg[47:32]};
    assign time_slot   = offset_reg - OFS_TIME;

    always_comb begin
        hdr_pos_next    = hdr_pos_reg;
        in_sent_next    = in_sent_reg;
        offset_next     = offset_reg;
        commas_next     = commas_reg;
        status_next     = status_reg;
        date_idx_next   = date_idx_reg;
        date_store_next = date_store_reg;
        time_store_next = time_store_reg;
        res_valid       = 1'b0;
        res_user        = status_reg;
        res_data        = status_reg ? {time_store_reg, date_yymmdd} : '0;

        if (s_accept) begin
            priority if (b == CH_DOLLAR) begin
                in_sent_next = 1'b0;
                hdr_pos_next = 3'd1;
            end else if (!in_sent_reg) begin
                if (hdr_pos_reg != 3'd0 && hdr_pos_reg < HDR_LEN &&
                    b == hdr_char(hdr_pos_reg)) begin
                    if (hdr_pos_reg + 3'd1 == HDR_LEN) begin
                        hdr_pos_next    = '0;
                        in_sent_next    = 1'b1;
                        offset_next     = OFS_AFTER_HDR;
                        commas_next     = '0;
                        status_next     = 1'b0;
                        date_idx_next   = '0;
                        date_store_next = '0;
                        time_store_next = '0;
                    end else begin
                        hdr_pos_next = hdr_pos_reg + 3'd1;
                    end
                end else begin
                    hdr_pos_next = '0;
                end
            end else if (b == CH_NEWLINE) begin
                in_sent_next = 1'b0;
                hdr_pos_next = '0;
                res_valid    = 1'b1;
            end else begin
                // time characters at offsets 7..12
                for (int k = 0; k < SLOTS; k++) begin
                    if (offset_reg >= OFS_TIME && time_slot == OFFSET_W'(k))
                        time_store_next[FIELD_W-1-CHAR_W*k -: CHAR_W] = b;
                end
                if (offset_reg == OFS_STATUS)
                    status_next = (b == CH_ACTIVE);
                // raw capture of six bytes after the ninth comma
                if (commas_reg >= DATE_COMMAS && date_idx_reg < DATE_LEN) begin
                    for (int k = 0; k < SLOTS; k++) begin
                        if (date_idx_reg == IDX_W'(k))
                            date_store_next[FIELD_W-1-CHAR_W*k -: CHAR_W] = b;
                    end
                    date_idx_next = date_idx_reg + 3'd1;
                end
                if (b == CH_COMMA && commas_reg < COMMA_MAX)
                    commas_next = commas_reg + 4'd1;
                if (offset_reg < OFS_MAX)
                    offset_next = offset_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg    <= '0;
            in_sent_reg    <= 1'b0;
            offset_reg     <= '0;
            commas_reg     <= '0;
            status_reg     <= 1'b0;
            date_idx_reg   <= '0;
            date_store_reg <= '0;
            time_store_reg <= '0;
        end else begin
            hdr_pos_reg    <= hdr_pos_next;
            in_sent_reg    <= in_sent_next;
            offset_reg     <= offset_next;
            commas_reg     <= commas_next;
            status_reg     <= status_next;
            date_idx_reg   <= date_idx_next;
            date_store_reg <= date_store_next;
            time_store_reg <= time_store_next;
        end
    end

    // output register + skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // no new input accepted while skid is full
            if (out_pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || out_pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_pop) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || out_pop) begin
                out_data_reg <= res_data;
                out_user_reg <= res_user;
            end else begin
                skid_data_reg <= res_data;
                skid_user_reg <= res_user;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // skid only fills behind a waiting output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // inactive fix carries zero characters
    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("inactive fix with nonzero characters");

    // inside a sentence, header matcher is idle and offset is past the header
    a_sentence_state: assert property (@(posedge aclk) disable iff (!aresetn)
        in_sent_reg |-> (hdr_pos_reg == '0 && offset_reg >= OFS_AFTER_HDR))
        else $error("inconsistent sentence state");

    // a full buffer holds until the receiver takes a word
    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry lost while stalled");
`endif

endmodule
